// ===== design/blifo_pkg.sv =====
// ----------------------------------------------------------------------------
// blifo_pkg
// Shared types, widths and codes for the bounded lifo stack.
// ----------------------------------------------------------------------------
package blifo_pkg;

    // built depth of the word store
    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_TRAV = 2'd3
    } blifo_func_t;

    // input item
    typedef struct packed {
        blifo_func_t              func;
        logic signed [WORD_W-1:0] push_value;
    } blifo_in_t;

    // result item
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [1:0]               status;
        logic                     last;
    } blifo_out_t;

    // store read address source
    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_ZERO = 2'd1,
        RD_NEXT = 2'd2
    } blifo_rd_src_t;

    // output register load source
    typedef enum logic [1:0] {
        OUT_PUSH  = 2'd0,
        OUT_OVF   = 2'd1,
        OUT_EMPTY = 2'd2,
        OUT_RD    = 2'd3
    } blifo_out_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic           push_we;
        logic           pop_dec;
        logic           idx_clr;
        logic           idx_inc;
        blifo_rd_src_t  rd_src;
        logic           out_ld;
        blifo_out_src_t out_src;
        logic           out_last;
    } blifo_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_last;
    } blifo_sts_t;

endpackage

// ===== design/blifo_dp.sv =====
// ----------------------------------------------------------------------------
// blifo_dp
// Datapath: word store, count, capacity, traverse index and output register.
// ----------------------------------------------------------------------------
module blifo_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [blifo_pkg::CAP_W-1:0] cfg_wdata,
    input  logic signed [blifo_pkg::WORD_W-1:0] push_value,
    input  blifo_pkg::blifo_cmd_t     cmd,
    output blifo_pkg::blifo_sts_t     sts,
    output blifo_pkg::blifo_out_t     out_item
);
    import blifo_pkg::*;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [ADDR_W-1:0] idx_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic [ADDR_W-1:0] rd_addr;
    logic [LIM_W-1:0]  cap_ext;
    logic [LIM_W-1:0]  limit;
    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    blifo_out_t        out_reg;
    blifo_out_t        out_next;

    // capacity saturated to the built depth
    assign cap_ext = LIM_W'(cap_reg);
    assign limit   = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;

    assign cnt_dec = count_reg - CNT_W'(1);
    assign idx_inc = idx_reg + ADDR_W'(1);

    assign sts.full     = (LIM_W'(count_reg) >= limit);
    assign sts.empty    = (count_reg == '0);
    assign sts.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // read address select
    always_comb
    begin
        case (cmd.rd_src)
            RD_TOP:  rd_addr = cnt_dec[ADDR_W-1:0];
            RD_ZERO: rd_addr = '0;
            RD_NEXT: rd_addr = idx_inc;
            default: rd_addr = cnt_dec[ADDR_W-1:0];
        endcase
    end

    // count and index update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_we)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop_dec)
            count_next = cnt_dec;

        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_inc;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // word store with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push_we)
            mem[count_reg[ADDR_W-1:0]] <= push_value;
        rd_data_reg <= mem[rd_addr];
    end

    // output register load
    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_ld)
        begin
            case (cmd.out_src)
                OUT_PUSH:
                begin
                    out_next.value  = push_value;
                    out_next.status = ST_OK;
                    out_next.last   = 1'b1;
                end
                OUT_OVF:
                begin
                    out_next.value  = '0;
                    out_next.status = ST_OVERFLOW;
                    out_next.last   = 1'b1;
                end
                OUT_EMPTY:
                begin
                    out_next.value  = '0;
                    out_next.status = ST_EMPTY;
                    out_next.last   = 1'b1;
                end
                OUT_RD:
                begin
                    out_next.value  = rd_data_reg;
                    out_next.status = ST_OK;
                    out_next.last   = cmd.out_last;
                end
                default:
                begin
                    out_next.value  = '0;
                    out_next.status = ST_EMPTY;
                    out_next.last   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

// ===== design/blifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// blifo_ctrl
// Controller: takes one item at a time and sequences store reads and results.
// ----------------------------------------------------------------------------
module blifo_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  blifo_pkg::blifo_func_t func,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  blifo_pkg::blifo_sts_t  sts,
    output blifo_pkg::blifo_cmd_t  cmd
);
    import blifo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   trav_reg;
    logic   trav_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        trav_next      = trav_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rd_src     = RD_TOP;
        cmd.out_src    = OUT_RD;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    trav_next = 1'b0;
                    case (func)
                        FUNC_PUSH:
                        begin
                            cmd.out_ld = 1'b1;
                            if (sts.full)
                                cmd.out_src = OUT_OVF;
                            else
                            begin
                                cmd.push_we = 1'b1;
                                cmd.out_src = OUT_PUSH;
                            end
                            state_next     = S_OUT;
                            out_valid_next = 1'b1;
                        end
                        FUNC_POP, FUNC_PEEK:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_ld     = 1'b1;
                                cmd.out_src    = OUT_EMPTY;
                                state_next     = S_OUT;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_dec = (func == FUNC_POP);
                                cmd.rd_src  = RD_TOP;
                                state_next  = S_READ;
                            end
                        end
                        FUNC_TRAV:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_ld     = 1'b1;
                                cmd.out_src    = OUT_EMPTY;
                                state_next     = S_OUT;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                cmd.idx_clr = 1'b1;
                                cmd.rd_src  = RD_ZERO;
                                trav_next   = 1'b1;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // store data is ready, move it to the output register
            S_READ:
            begin
                cmd.out_ld     = 1'b1;
                cmd.out_src    = OUT_RD;
                cmd.out_last   = !trav_reg || sts.idx_last;
                state_next     = S_OUT;
                out_valid_next = 1'b1;
            end

            // hold the result until taken
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (trav_reg && !sts.idx_last)
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_src  = RD_NEXT;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        trav_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
                trav_next      = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            trav_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            trav_reg      <= trav_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/bounded_lifo_stack.sv =====
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded last-in first-out stack of signed 32-bit words.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one item: func and push_value.
// Push, pop and peek give one result; traverse gives one result per held
// word, bottom to top, with last set on the top word. Errors (push on a full
// stack, pop/peek/traverse on an empty one) give one result with value 0.
// Output channel out_valid/out_stall carries value, status and last.
// Items are taken one at a time: in_stall is high from the cycle after an
// item is taken until its final result has been taken.
// Push and error results appear in the cycle after the item is taken;
// pop, peek and each traverse word pass first through the registered store
// read and then through the output register.
// A stalled result holds in the output register and the store waits.
// Reset empties the stack and sets capacity to 16; store contents stay
// undefined and are never read before being pushed. cfg_we writes capacity
// (limit is min(capacity, 16)) and is meant for use while the block is idle.
// ----------------------------------------------------------------------------
module bounded_lifo_stack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  blifo_pkg::blifo_in_t          in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output blifo_pkg::blifo_out_t         out_item,
    input  logic                          cfg_we,
    input  logic [blifo_pkg::CAP_W-1:0]   cfg_wdata
);
    import blifo_pkg::*;

    blifo_cmd_t cmd;
    blifo_sts_t sts;

    // sequencing
    blifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (in_item.func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and result register
    blifo_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push_value (in_item.push_value),
        .cmd        (cmd),
        .sts        (sts),
        .out_item   (out_item)
    );

endmodule

// ===== design/blifo_chk.sv =====
// ----------------------------------------------------------------------------
// blifo_chk
// Port-level checks for the bounded lifo stack.
// ----------------------------------------------------------------------------
module blifo_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input blifo_pkg::blifo_out_t out_item
);
    import blifo_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // the block is busy after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken while previous item still in work");

    // no result pending while the input side is open
    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("result pending while input open");

    // error results are single and carry a zero word
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_OVERFLOW || out_item.status == ST_EMPTY)
        |-> out_item.last && (out_item.value == '0))
        else $error("error result not final or not zero");

endmodule

bind bounded_lifo_stack blifo_chk u_blifo_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
